[rtl/stcs_pkg.sv]
// shared types and constants for the sparse tensor chunk splitter
package stcs_pkg;

  localparam int MODES_DEF      = 4;
  localparam int INDEX_BITS_DEF = 32;
  localparam int FIELD_MODES    = 4;
  localparam int COORD_W        = 32;
  localparam int HIGH_W         = 33;
  localparam int COUNT_W        = 32;
  localparam int OUTQ_DEPTH     = 4;
  localparam int OUTQ_PTR_W     = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_LVL_W     = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_SPLIT_MODE = 2'd0,
    CFG_CHUNK_SPAN = 2'd1,
    CFG_MODE_COUNT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_LAST  = 2'd0,
    KIND_MORE  = 2'd1,
    KIND_FINAL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  split_mode;
    logic [31:0] chunk_span;
    logic [2:0]  mode_count;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic absorb;
  } lane_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                     nonzero_total;
    logic [COUNT_W-1:0]                     span_covered;
    logic [FIELD_MODES-1:0][COORD_W-1:0]    low;
    logic [FIELD_MODES-1:0][HIGH_W-1:0]     high;
    logic                                   order_error;
    kind_t                                  result_kind;
  } result_t;

  typedef struct packed {
    logic                  room;
    logic [OUTQ_LVL_W-1:0] level;
  } q_status_t;

endpackage

[rtl/stcs_lane.sv]
// per-mode bounding box lane
module stcs_lane #(
  parameter int INDEX_BITS = stcs_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  stcs_pkg::lane_ctl_t   ctl,
  input  logic                  in_use,
  input  logic [INDEX_BITS-1:0] coord,
  output logic [INDEX_BITS-1:0] low,
  output logic [INDEX_BITS-1:0] high,
  output logic [INDEX_BITS-1:0] low_next,
  output logic [INDEX_BITS-1:0] high_next
);
  import stcs_pkg::*;

  always_comb begin
    low_next  = low;
    high_next = high;
    if (ctl.load) begin
      low_next  = coord;
      high_next = coord;
    end else if (ctl.absorb && in_use) begin
      if (coord < low) begin
        low_next = coord;
      end
      if (coord > high) begin
        high_next = coord;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.absorb) begin
      low  <= low_next;
      high <= high_next;
    end
  end

endmodule

[rtl/stcs_merge.sv]
// chunk control: span check, counts, order flag and result records
module stcs_merge #(
  parameter int MODES      = stcs_pkg::MODES_DEF,
  parameter int INDEX_BITS = stcs_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stcs_pkg::cfg_t                    cfg,
  input  logic                              accept,
  input  logic                              last,
  input  logic [MODES-1:0][INDEX_BITS-1:0]  coord,
  input  logic [MODES-1:0][INDEX_BITS-1:0]  box_low,
  input  logic [MODES-1:0][INDEX_BITS-1:0]  box_high,
  input  logic [MODES-1:0][INDEX_BITS-1:0]  box_low_next,
  input  logic [MODES-1:0][INDEX_BITS-1:0]  box_high_next,
  output stcs_pkg::lane_ctl_t               lane_ctl,
  output logic [MODES-1:0]                  lane_use,
  output logic                              chunk_open,
  output logic [1:0]                        push,
  output stcs_pkg::result_t                 rec0,
  output stcs_pkg::result_t                 rec1
);
  import stcs_pkg::*;

  localparam int         MODE_BITS = $clog2(MODES);
  localparam logic [2:0] MODES_W   = 3'(MODES);

  logic [INDEX_BITS-1:0] first_idx, first_idx_next;
  logic [INDEX_BITS-1:0] latest_idx, latest_idx_next;
  logic [COUNT_W-1:0]    nonzeros, nonzeros_next;
  logic                  order_err, order_err_next;
  logic                  chunk_open_next;

  logic [2:0]            used;
  logic [1:0]            cut;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] gap;
  logic [31:0]           limit;
  logic                  overflow;

  function automatic result_t make_rec(
    input logic [COUNT_W-1:0]                nnz,
    input logic [INDEX_BITS-1:0]             first_i,
    input logic [INDEX_BITS-1:0]             latest_i,
    input logic [MODES-1:0][INDEX_BITS-1:0]  lo,
    input logic [MODES-1:0][INDEX_BITS-1:0]  hi,
    input logic [MODES-1:0]                  use_mask,
    input logic                              err,
    input kind_t                             kind
  );
    result_t               r;
    logic [INDEX_BITS-1:0] d;
    d               = latest_i - first_i;
    r.nonzero_total = nnz;
    r.span_covered  = COUNT_W'(d) + COUNT_W'(1);
    r.low           = '0;
    r.high          = '0;
    for (int k = 0; k < MODES; k++) begin
      if (use_mask[k]) begin
        r.low[k]  = COORD_W'(lo[k]);
        r.high[k] = HIGH_W'(hi[k]) + HIGH_W'(1);
      end
    end
    r.order_error = err;
    r.result_kind = kind;
    return r;
  endfunction

  always_comb begin
    if (cfg.mode_count < 3'd2) begin
      used = 3'd2;
    end else if (cfg.mode_count > MODES_W) begin
      used = MODES_W;
    end else begin
      used = cfg.mode_count;
    end
    cut = ({1'b0, cfg.split_mode} < used) ? cfg.split_mode : 2'd0;
    for (int k = 0; k < MODES; k++) begin
      lane_use[k] = 3'(k) < used;
    end
  end

  assign idx      = coord[cut[MODE_BITS-1:0]];
  assign gap      = idx - first_idx;
  assign limit    = (cfg.chunk_span == 32'd0) ? 32'd1 : cfg.chunk_span;
  assign overflow = chunk_open && (idx > latest_idx) && (32'(gap) >= limit);

  assign lane_ctl.load   = accept && (!chunk_open || overflow);
  assign lane_ctl.absorb = accept && chunk_open && !overflow;

  always_comb begin
    first_idx_next  = first_idx;
    latest_idx_next = latest_idx;
    nonzeros_next   = nonzeros;
    order_err_next  = order_err;
    chunk_open_next = chunk_open;
    if (lane_ctl.load) begin
      first_idx_next  = idx;
      latest_idx_next = idx;
      nonzeros_next   = COUNT_W'(1);
      order_err_next  = 1'b0;
    end else if (lane_ctl.absorb) begin
      if (idx > latest_idx) begin
        latest_idx_next = idx;
      end else if (idx < latest_idx) begin
        order_err_next = 1'b1;
      end
      if (nonzeros != '1) begin
        nonzeros_next = nonzeros + COUNT_W'(1);
      end
    end
    if (accept) begin
      chunk_open_next = !last;
    end
  end

  always_comb begin
    push = 2'd0;
    if (accept) begin
      if (overflow) begin
        push = last ? 2'd2 : 2'd1;
      end else begin
        push = last ? 2'd1 : 2'd0;
      end
    end
    if (overflow) begin
      rec0 = make_rec(nonzeros, first_idx, latest_idx, box_low, box_high, lane_use,
                      order_err, last ? KIND_MORE : KIND_LAST);
    end else begin
      rec0 = make_rec(nonzeros_next, first_idx_next, latest_idx_next, box_low_next,
                      box_high_next, lane_use, order_err_next, KIND_FINAL);
    end
    rec1 = make_rec(nonzeros_next, first_idx_next, latest_idx_next, box_low_next,
                    box_high_next, lane_use, order_err_next, KIND_FINAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_open <= 1'b0;
      first_idx  <= '0;
      latest_idx <= '0;
      nonzeros   <= '0;
      order_err  <= 1'b0;
    end else begin
      chunk_open <= chunk_open_next;
      first_idx  <= first_idx_next;
      latest_idx <= latest_idx_next;
      nonzeros   <= nonzeros_next;
      order_err  <= order_err_next;
    end
  end

endmodule

[rtl/stcs_outq.sv]
// result queue, up to two words in and one word out per cycle when the head is taken
module stcs_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push,
  input  stcs_pkg::result_t    rec0,
  input  stcs_pkg::result_t    rec1,
  output stcs_pkg::result_t    head,
  output logic                 head_valid,
  input  logic                 head_take,
  output stcs_pkg::q_status_t  status
);
  import stcs_pkg::*;

  result_t                 slots [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wptr;
  logic [OUTQ_PTR_W-1:0]   rptr;
  logic [OUTQ_LVL_W-1:0]   level;
  logic                    take;

  assign head_valid    = level != '0;
  assign take          = head_take && head_valid;
  assign head          = slots[rptr];
  assign status.level  = level;
  assign status.room   = level <= OUTQ_LVL_W'(OUTQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      slots[wptr] <= rec0;
    end
    if (push == 2'd2) begin
      slots[OUTQ_PTR_W'(wptr + OUTQ_PTR_W'(1))] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + OUTQ_PTR_W'(push);
      rptr  <= rptr + OUTQ_PTR_W'(take);
      level <= level + OUTQ_LVL_W'(push) - OUTQ_LVL_W'(take);
    end
  end

endmodule

[rtl/sparse_tensor_chunk_splitter_top.sv]
// top level of the sparse tensor chunk splitter
// a taken nonzero's results go into the result queue, whose head drives the master side
// throughput: one nonzero per cycle while the four-word result queue has room for two
// results drain one word per cycle while m_axis_tready is high; a nonzero closing two
// chunks queues two words; closes use the span subtract and compare of the control stage
// reset (rst, synchronous): no chunk open, queue empty, config registers to their defaults
module sparse_tensor_chunk_splitter_top #(
  parameter int MODES      = stcs_pkg::MODES_DEF,
  parameter int INDEX_BITS = stcs_pkg::INDEX_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // coord_a, coord_b, coord_c, coord_d
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // nonzero_total, span_covered, low_a..low_d, high_a..high_d, zero fill
  output logic [327:0] m_axis_tdata,
  // order_error, result_kind
  output logic [2:0]   m_axis_tuser
);
  import stcs_pkg::*;

  cfg_t                             cfg;
  logic                             accept;
  logic [MODES-1:0][INDEX_BITS-1:0] coord;
  logic [MODES-1:0][INDEX_BITS-1:0] box_low, box_high, box_low_next, box_high_next;
  lane_ctl_t                        lane_ctl;
  logic [MODES-1:0]                 lane_use;
  logic                             chunk_open;
  logic [1:0]                       push;
  result_t                          rec0, rec1, head;
  q_status_t                        q_status;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = q_status.room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.split_mode <= 2'd0;
      cfg.chunk_span <= 32'd1;
      cfg.mode_count <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPLIT_MODE: cfg.split_mode <= cfg_data[1:0];
        CFG_CHUNK_SPAN: cfg.chunk_span <= cfg_data;
        CFG_MODE_COUNT: cfg.mode_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < MODES; k++) begin : g_lane
    assign coord[k] = s_axis_tdata[COORD_W*k +: INDEX_BITS];

    stcs_lane #(
      .INDEX_BITS(INDEX_BITS)
    ) u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .in_use   (lane_use[k]),
      .coord    (coord[k]),
      .low      (box_low[k]),
      .high     (box_high[k]),
      .low_next (box_low_next[k]),
      .high_next(box_high_next[k])
    );
  end

  stcs_merge #(
    .MODES     (MODES),
    .INDEX_BITS(INDEX_BITS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .last         (s_axis_tlast),
    .coord        (coord),
    .box_low      (box_low),
    .box_high     (box_high),
    .box_low_next (box_low_next),
    .box_high_next(box_high_next),
    .lane_ctl     (lane_ctl),
    .lane_use     (lane_use),
    .chunk_open   (chunk_open),
    .push         (push),
    .rec0         (rec0),
    .rec1         (rec1)
  );

  stcs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rec0      (rec0),
    .rec1      (rec1),
    .head      (head),
    .head_valid(m_axis_tvalid),
    .head_take (m_axis_tready),
    .status    (q_status)
  );

  assign m_axis_tdata = {4'b0,
                         head.high[3], head.high[2], head.high[1], head.high[0],
                         head.low[3], head.low[2], head.low[1], head.low[0],
                         head.span_covered, head.nonzero_total};
  assign m_axis_tuser = {head.result_kind, head.order_error};

  a_room: assert property (@(posedge clk) disable iff (rst)
    accept |-> q_status.level <= OUTQ_LVL_W'(OUTQ_DEPTH - 2))
    else $error("nonzero taken without room for two results");

  a_level: assert property (@(posedge clk) disable iff (rst)
    q_status.level <= OUTQ_LVL_W'(OUTQ_DEPTH))
    else $error("result queue overrun");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> !chunk_open)
    else $error("chunk left open after end of tensor");

  a_final_out: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result queued for end of tensor");

endmodule

[tb/tb_sparse_tensor_chunk_splitter_top.sv]
// testbench for the sparse tensor chunk splitter: directed table, random tensors, own predictor
module tb_sparse_tensor_chunk_splitter_top;
  import stcs_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam logic [32:0] TOP = 33'h1_0000_0000;

  typedef logic [3:0][31:0] coords_t;

  typedef struct {
    bit         is_write;
    cfg_index_t reg_sel;
    logic [31:0] reg_val;
    coords_t    coord;
    bit         tail;
    bit         typed;
    result_t    want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = CFG_SPLIT_MODE;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [327:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int mismatches = 0;
  result_t chunks_due[$];
  result_t head;
  row_t plan[$];

  // predictor state
  logic [1:0]  cut_mode_reg = 2'd0;
  logic [31:0] span_reg = 32'd1;
  logic [2:0]  modes_reg = 3'd3;
  bit          chunk_live = 1'b0;
  logic [31:0] first_idx = '0;
  logic [31:0] last_idx = '0;
  logic [31:0] nz_count = '0;
  logic [31:0] lo [4] = '{default: '0};
  logic [31:0] hi [4] = '{default: '0};
  bit          order_bad = 1'b0;

  sparse_tensor_chunk_splitter_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned modes_in_use();
    int unsigned n;
    n = 32'(modes_reg);
    if (n < 2) n = 2;
    if (n > 4) n = 4;
    return n;
  endfunction

  function automatic int unsigned cut_axis();
    return (32'(cut_mode_reg) < modes_in_use()) ? 32'(cut_mode_reg) : 32'd0;
  endfunction

  function automatic void start_chunk(input coords_t c);
    chunk_live = 1'b1;
    nz_count = 32'd1;
    order_bad = 1'b0;
    for (int m = 0; m < 4; m++) begin
      lo[m] = c[m];
      hi[m] = c[m];
    end
    first_idx = c[cut_axis()];
    last_idx = first_idx;
  endfunction

  function automatic result_t chunk_report(input kind_t k);
    result_t r;
    int unsigned n;
    n = modes_in_use();
    r.nonzero_total = nz_count;
    r.span_covered = last_idx - first_idx + 32'd1;
    for (int m = 0; m < 4; m++) begin
      r.low[m] = (m < n) ? lo[m] : '0;
      r.high[m] = (m < n) ? {1'b0, hi[m]} + 33'd1 : '0;
    end
    r.order_error = order_bad;
    r.result_kind = k;
    return r;
  endfunction

  function automatic int split_nonzero(input coords_t c, input bit tail,
                                       output result_t r0, output result_t r1);
    int cnt;
    logic [31:0] idx;
    logic [32:0] limit;
    bit over;
    int unsigned n;
    cnt = 0;
    r0 = '0;
    r1 = '0;
    if (!chunk_live) begin
      start_chunk(c);
    end else begin
      limit = (span_reg == '0) ? 33'd1 : {1'b0, span_reg};
      idx = c[cut_axis()];
      over = (idx > last_idx) && ({1'b0, idx} - {1'b0, first_idx} + 33'd1 > limit);
      if (over) begin
        r0 = chunk_report(tail ? KIND_MORE : KIND_LAST);
        cnt = 1;
        start_chunk(c);
      end else begin
        if (idx > last_idx) last_idx = idx;
        else if (idx < last_idx) order_bad = 1'b1;
        if (nz_count != '1) nz_count = nz_count + 32'd1;
        n = modes_in_use();
        for (int k = 0; k < 4; k++) begin
          if (k < n) begin
            if (c[k] < lo[k]) lo[k] = c[k];
            if (c[k] > hi[k]) hi[k] = c[k];
          end
        end
      end
    end
    if (tail) begin
      if (cnt == 0) r0 = chunk_report(KIND_FINAL);
      else r1 = chunk_report(KIND_FINAL);
      cnt++;
      chunk_live = 1'b0;
    end
    return cnt;
  endfunction

  function automatic result_t typed_result(input logic [31:0] total, input logic [31:0] span,
                                           input logic [3:0][31:0] low,
                                           input logic [3:0][32:0] high,
                                           input bit err, input kind_t k);
    result_t r;
    r.nonzero_total = total;
    r.span_covered = span;
    r.low = low;
    r.high = high;
    r.order_error = err;
    r.result_kind = k;
    return r;
  endfunction

  function automatic row_t nz_row(input coords_t c, input bit tail);
    row_t r;
    r.is_write = 1'b0;
    r.reg_sel = CFG_SPLIT_MODE;
    r.reg_val = '0;
    r.coord = c;
    r.tail = tail;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t typed_row(input coords_t c, input bit tail, input result_t want);
    row_t r;
    r = nz_row(c, tail);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic row_t reg_row(input cfg_index_t sel, input logic [31:0] val);
    row_t r;
    r = nz_row('0, 1'b0);
    r.is_write = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  task automatic send_nonzero(input coords_t c, input bit tail, input bit typed,
                              input result_t want);
    result_t r0, r1;
    int cnt;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= tail;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    cnt = split_nonzero(c, tail, r0, r1);
    if (typed) begin
      chunks_due.push_back(want);
    end else begin
      if (cnt > 0) chunks_due.push_back(r0);
      if (cnt > 1) chunks_due.push_back(r1);
    end
  endtask

  task automatic write_reg(input cfg_index_t sel, input logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk);
    // let a nonzero that closes nothing settle
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (sel)
      CFG_SPLIT_MODE: cut_mode_reg = val[1:0];
      CFG_CHUNK_SPAN: span_reg = val;
      CFG_MODE_COUNT: modes_reg = val[2:0];
      default: ;
    endcase
  endtask

  task automatic run_tensors(input int budget);
    coords_t c;
    logic [31:0] idx, incr;
    int len, sent;
    bit broken, tail;
    result_t none;
    none = '0;
    sent = 0;
    idx = '0;
    while (sent < budget) begin
      len = $urandom_range(1, 30);
      idx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
      broken = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len && sent < budget; i++) begin
        for (int m = 0; m < 4; m++)
          c[m] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
        case ($urandom_range(0, 19))
          0: idx = idx - $urandom_range(1, 5);
          1, 2: begin
            incr = $urandom_range(3, 40);
            idx = (idx > ~incr) ? '1 : idx + incr;
          end
          default: begin
            incr = $urandom_range(0, 2);
            idx = (idx > ~incr) ? '1 : idx + incr;
          end
        endcase
        c[cut_axis()] = idx;
        tail = (i == len - 1) ? !broken : ($urandom_range(0, 49) == 0);
        send_nonzero(c, tail, 1'b0, none);
        sent++;
      end
    end
  endtask

  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [32:0] want,
                             input logic [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin : watch
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (chunks_due.size() == 0) begin
        $error("result word with no chunk expected");
        mismatches++;
      end else begin
        head = chunks_due.pop_front();
        check_field("nonzero_total", 33'(head.nonzero_total), 33'(m_axis_tdata[31:0]));
        check_field("span_covered", 33'(head.span_covered), 33'(m_axis_tdata[63:32]));
        for (int m = 0; m < 4; m++) begin
          check_field($sformatf("low_%s", m == 0 ? "a" : m == 1 ? "b" : m == 2 ? "c" : "d"),
                      33'(head.low[m]), 33'(m_axis_tdata[64 + 32 * m +: 32]));
          check_field($sformatf("high_%s", m == 0 ? "a" : m == 1 ? "b" : m == 2 ? "c" : "d"),
                      head.high[m], m_axis_tdata[192 + 33 * m +: 33]);
        end
        check_field("order_error", 33'(head.order_error), 33'(m_axis_tuser[0]));
        check_field("result_kind", 33'(head.result_kind), 33'(m_axis_tuser[2:1]));
      end
    end
  end

  initial begin : stimulus
    coords_t c;
    result_t none;
    none = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: cut along mode a, span one, three modes
    plan.push_back(typed_row({32'd9, 32'd3, 32'd2, 32'd7}, 1'b1,
      typed_result(32'd1, 32'd1, {32'd0, 32'd3, 32'd2, 32'd7},
                   {33'd0, 33'd4, 33'd3, 33'd8}, 1'b0, KIND_FINAL)));
    plan.push_back(typed_row('1, 1'b1,
      typed_result(32'd1, 32'd1, {32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                   {33'd0, TOP, TOP, TOP}, 1'b0, KIND_FINAL)));
    plan.push_back(typed_row('0, 1'b1,
      typed_result(32'd1, 32'd1, '0, {33'd0, 33'd1, 33'd1, 33'd1}, 1'b0, KIND_FINAL)));
    // zero span behaves as one; decrease flags the chunk
    plan.push_back(reg_row(CFG_CHUNK_SPAN, 32'd0));
    plan.push_back(nz_row({32'd1, 32'd1, 32'd1, 32'd10}, 1'b0));
    plan.push_back(nz_row({32'd2, 32'd0, 32'd5, 32'd10}, 1'b0));
    plan.push_back(nz_row({32'd0, 32'd0, 32'd0, 32'd11}, 1'b0));
    plan.push_back(nz_row({32'd4, 32'd4, 32'd4, 32'd9}, 1'b1));
    // split mode beyond used modes falls back to mode a; overflow on the last word
    plan.push_back(reg_row(CFG_CHUNK_SPAN, 32'd4));
    plan.push_back(reg_row(CFG_SPLIT_MODE, 32'd3));
    plan.push_back(nz_row({32'd9, 32'd8, 32'd7, 32'd100}, 1'b0));
    plan.push_back(nz_row({32'd1, 32'd9, 32'd6, 32'd101}, 1'b0));
    plan.push_back(nz_row({32'd5, 32'd2, 32'd8, 32'd99}, 1'b0));
    plan.push_back(nz_row({32'd3, 32'd3, 32'd3, 32'd104}, 1'b1));
    // mode count above range acts as four
    plan.push_back(reg_row(CFG_MODE_COUNT, 32'd7));
    plan.push_back(nz_row({32'd0, 32'd6, 32'd6, 32'd5}, 1'b0));
    plan.push_back(nz_row({32'd3, 32'd1, 32'd7, 32'd5}, 1'b0));
    plan.push_back(nz_row({32'hFFFF_FFFF, 32'd2, 32'd2, 32'd2}, 1'b1));
    // mode count below range acts as two
    plan.push_back(reg_row(CFG_MODE_COUNT, 32'd0));
    plan.push_back(reg_row(CFG_SPLIT_MODE, 32'd1));
    plan.push_back(nz_row({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 32'd1}, 1'b0));
    plan.push_back(nz_row({32'd0, 32'd0, 32'd6, 32'd2}, 1'b1));
    // widest span still overflows across the full index range
    plan.push_back(reg_row(CFG_MODE_COUNT, 32'd4));
    plan.push_back(reg_row(CFG_SPLIT_MODE, 32'd2));
    plan.push_back(reg_row(CFG_CHUNK_SPAN, 32'hFFFF_FFFF));
    plan.push_back(nz_row({32'd1, 32'd0, 32'd1, 32'd1}, 1'b0));
    plan.push_back(nz_row({32'd2, 32'hFFFF_FFFF, 32'd2, 32'd2}, 1'b0));
    plan.push_back(nz_row({32'd3, 32'd5, 32'd3, 32'd3}, 1'b1));
    // register change while a chunk is open
    plan.push_back(reg_row(CFG_CHUNK_SPAN, 32'd2));
    plan.push_back(nz_row({32'd0, 32'd50, 32'd0, 32'd0}, 1'b0));
    plan.push_back(reg_row(CFG_CHUNK_SPAN, 32'd10));
    plan.push_back(nz_row({32'd1, 32'd58, 32'd1, 32'd1}, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].reg_sel, plan[i].reg_val);
      else send_nonzero(plan[i].coord, plan[i].tail, plan[i].typed, plan[i].want);
    end

    // every word after the first closes a chunk while the sink holds off
    write_reg(CFG_SPLIT_MODE, 32'd0);
    write_reg(CFG_CHUNK_SPAN, 32'd1);
    write_reg(CFG_MODE_COUNT, 32'd3);
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++) begin
      c = {$urandom, $urandom, $urandom, 32'd1000 + i};
      send_nonzero(c, i == 79, 1'b0, none);
    end

    for (int p = 0; p < 9; p++) begin
      if (p == 8) gaps_on = 1'b0;
      write_reg(CFG_SPLIT_MODE, $urandom_range(0, 3));
      write_reg(CFG_MODE_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                            : $urandom_range(2, 4));
      case ($urandom_range(0, 7))
        0: write_reg(CFG_CHUNK_SPAN, 32'd0);
        1: write_reg(CFG_CHUNK_SPAN, 32'd1);
        2: write_reg(CFG_CHUNK_SPAN, 32'd2);
        3: write_reg(CFG_CHUNK_SPAN, $urandom_range(3, 20));
        4: write_reg(CFG_CHUNK_SPAN, $urandom);
        5: write_reg(CFG_CHUNK_SPAN, 32'hFFFF_FFFF);
        default: write_reg(CFG_CHUNK_SPAN, $urandom_range(1, 64));
      endcase
      run_tensors(110);
    end

    s_axis_tvalid <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
